// File: rtl/core/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the substring search matcher
// Register map, configuration and result bundles, and the letter fold helper.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default sizing
  localparam int PatternMaxDef = 32;
  localparam int OffsetBitsDef = 16;

  // Fixed storage of the pattern registers
  localparam int PatBytes   = 32;
  localparam int PatWords   = 4;
  localparam int CfgAddrW   = 6;
  localparam int CfgDataW   = 64;
  localparam int LenW       = 6;
  localparam int StartW     = 16;

  // Register indexes (byte address / 8)
  localparam logic [2:0] RegPatLow    = 3'd0;
  localparam logic [2:0] RegPatSecond = 3'd1;
  localparam logic [2:0] RegPatThird  = 3'd2;
  localparam logic [2:0] RegPatHigh   = 3'd3;
  localparam logic [2:0] RegPatLength = 3'd4;
  localparam logic [2:0] RegCaseIns   = 3'd5;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [PatBytes*8-1:0] pattern;
    logic [LenW-1:0]       length;
    logic                  fold_en;
  } cfg_t;

  // Control handed to every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold_en;
  } cell_ctrl_t;

  // One result beat
  typedef struct packed {
    logic              found;
    logic [StartW-1:0] start;
  } out_beat_t;

  // Fold ASCII a-z to A-Z when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h61) && (c <= 8'h7A)) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ssm_cfg.sv
// ----------------------------------------------------------------------------
// ssm_cfg: configuration registers
// APB-style slave holding the pattern, its length and the case fold flag.
// ----------------------------------------------------------------------------
module ssm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ssm_pkg::CfgDataW-1:0]  pwdata,
  output logic [ssm_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ssm_pkg::cfg_t                 cfg_o
);
  import ssm_pkg::*;

  logic [CfgDataW-1:0] pat0_q, pat1_q, pat2_q, pat3_q;
  logic [LenW-1:0]     len_q;
  logic                fold_q;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat0_q <= '0;
      pat1_q <= '0;
      pat2_q <= '0;
      pat3_q <= '0;
      len_q  <= '0;
      fold_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegPatLow:    pat0_q <= pwdata;
        RegPatSecond: pat1_q <= pwdata;
        RegPatThird:  pat2_q <= pwdata;
        RegPatHigh:   pat3_q <= pwdata;
        RegPatLength: len_q  <= pwdata[LenW-1:0];
        RegCaseIns:   fold_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      RegPatLow:    prdata = pat0_q;
      RegPatSecond: prdata = pat1_q;
      RegPatThird:  prdata = pat2_q;
      RegPatHigh:   prdata = pat3_q;
      RegPatLength: prdata = {{(CfgDataW-LenW){1'b0}}, len_q};
      RegCaseIns:   prdata = {{(CfgDataW-1){1'b0}}, fold_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.pattern = {pat3_q, pat2_q, pat1_q, pat0_q};
  assign cfg_o.length  = len_q;
  assign cfg_o.fold_en = fold_q;

endmodule

// File: rtl/core/ssm_cell.sv
// ----------------------------------------------------------------------------
// ssm_cell: one position of the text window
// Takes the byte from its left neighbor, compares it with its pattern byte
// and holds it for the next neighbor.
// ----------------------------------------------------------------------------
module ssm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssm_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          pat_i,
  output logic [7:0]          byte_o,
  output logic                eq_o
);
  import ssm_pkg::*;

  logic [7:0] byte_q, byte_d;

  // Compare the byte that is about to enter this position
  assign eq_o = (fold_byte(byte_i, ctrl_i.fold_en) == fold_byte(pat_i, ctrl_i.fold_en));

  // Shift in, or drop the window at the end of a text
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/core/ssm_out_buf.sv
// ----------------------------------------------------------------------------
// ssm_out_buf: result output register with skid stage
// Two-entry buffer so the input side keeps running while a result waits.
// ----------------------------------------------------------------------------
module ssm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ssm_pkg::out_beat_t  beat_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ssm_pkg::out_beat_t  beat_o
);
  import ssm_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t out_q, out_d;
  out_beat_t skid_q, skid_d;
  logic      pop;

  assign pop = out_valid_q && ready_i;

  // Advance the two stages
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_d       = beat_i;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = push_i;
      if (push_i) begin
        out_d = beat_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign beat_o  = out_q;

`ifndef NO_ASSERTIONS
  // A full buffer never takes another beat
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed into full buffer");

  // The skid stage only holds a beat behind a valid output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat without output beat");
`endif

endmodule

// File: rtl/core/substring_search_matcher.sv
// ----------------------------------------------------------------------------
// substring_search_matcher: streaming first-match finder
// Chain of byte cells holds the recent text; every pattern byte is compared
// in parallel with the text window and the leftmost match start is reported.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser   tlast
//  s_axis    in   [7:0] text_byte       -       final_byte
//  m_axis    out  [15:0] match_start    found   -
//  apb       in   64-bit regs at 8*i    -       -
//
// One text byte is taken every cycle while s_axis_tready_o is high; its result,
// if any, is registered and shows on m_axis the next cycle unless an earlier
// result still waits there. The throughput is set by the cell chain, which
// shifts one byte per accepted beat. s_axis_tready_o drops only while two
// results wait on m_axis. Reset clears the window, offset and state.
// ----------------------------------------------------------------------------
module substring_search_matcher #(
  parameter int PatternMax = ssm_pkg::PatternMaxDef,
  parameter int OffsetBits = ssm_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // text input
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] text_byte
  input  logic                          s_axis_tlast_i,   // final_byte
  // result output
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,   // [15:0] match_start
  output logic                          m_axis_tuser_o,   // [0] found
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ssm_pkg::CfgDataW-1:0]  pwdata,
  output logic [ssm_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ssm_pkg::*;

  localparam int ExtW = (OffsetBits > StartW) ? OffsetBits : StartW;
  localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};

  cfg_t                  cfg;
  cell_ctrl_t            ctrl;
  out_beat_t             res_beat, out_beat;
  logic                  buf_full;
  logic                  in_acc;
  logic [LenW-1:0]       len_c;
  logic [PatternMax-1:0] eq_vec, use_vec;
  logic [7:0]            chain_byte [PatternMax];
  logic                  all_eq, hit, res_push;
  logic [OffsetBits-1:0] seen_q, seen_d, len_m1, start_full;
  logic [ExtW-1:0]       start_ext;
  logic                  reported_q, reported_d;

  // Configuration registers
  ssm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready_o = !buf_full;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Clamp the length to the cells that exist
  assign len_c  = (cfg.length > LenW'(PatternMax)) ? LenW'(PatternMax) : cfg.length;
  assign len_m1 = OffsetBits'(len_c) - OffsetBits'(1);

  assign ctrl.shift   = in_acc;
  assign ctrl.clear   = s_axis_tlast_i;
  assign ctrl.fold_en = cfg.fold_en;

  // Row of window cells; cell k sees text byte k places back
  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic [LenW-1:0] pidx;
    logic [7:0]      cell_in;
    logic [7:0]      pat_sel;

    assign pidx    = len_c - LenW'(k) - LenW'(1);
    assign pat_sel = cfg.pattern[pidx[4:0]*8 +: 8];
    if (k == 0) begin : g_head
      assign cell_in = s_axis_tdata_i;
    end else begin : g_body
      assign cell_in = chain_byte[k-1];
    end
    assign use_vec[k] = (LenW'(k) < len_c);

    ssm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (cell_in),
      .pat_i  (pat_sel),
      .byte_o (chain_byte[k]),
      .eq_o   (eq_vec[k])
    );
  end

  // Match at this byte when every used cell agrees
  assign all_eq = &(eq_vec | ~use_vec);
  assign hit    = !reported_q && (len_c != '0) && (seen_q >= len_m1) && all_eq;

  // Start offset, held at the top once the count saturates
  assign start_full = (seen_q == OffsetMax) ? OffsetMax : (seen_q - len_m1);
  assign start_ext  = ExtW'(start_full);

  assign res_push       = in_acc && (hit || (s_axis_tlast_i && !reported_q));
  assign res_beat.found = hit;
  assign res_beat.start = hit ? start_ext[StartW-1:0] : '0;

  // Per-text state: byte count and match flag
  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (in_acc) begin
      if (s_axis_tlast_i) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        reported_d = reported_q || hit;
        if (seen_q != OffsetMax) begin
          seen_d = seen_q + OffsetBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Result buffer
  ssm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .beat_i  (res_beat),
    .full_o  (buf_full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .beat_o  (out_beat)
  );

  assign m_axis_tdata_o = out_beat.start;
  assign m_axis_tuser_o = out_beat.found;

`ifndef NO_ASSERTIONS
  // Once a match is given, the rest of that text stays silent
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && reported_q) |-> !res_push)
    else $error("second result for one text");

  // A final byte restarts the byte count
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (seen_q == '0) && !reported_q)
    else $error("state not cleared after final byte");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: first-match search over a streamed text
// Streams text beats into the matcher and loads the pattern over APB while the
// matcher is idle. A local search model predicts the single verdict that each
// text yields, which is then compared field by field with the result beats.
// It runs a directed table first, then random phases with planted, varied and
// broken patterns; the closing phases run without any idling.
// ----------------------------------------------------------------------------
module tb_top;
  import ssm_pkg::*;

  localparam realtime ClkPeriod   = 12ns;
  localparam realtime RunLimit    = 7.2ms;
  localparam int      DrainCycles = 8;
  localparam int      PhaseCount  = 16;
  localparam int      PhaseItems  = 42;

  // How a directed row gets its expected verdict
  typedef enum logic [1:0] {ExpPredict, ExpNone, ExpBeat} expect_e;
  typedef enum logic {RowCfg, RowText} row_kind_e;
  typedef enum logic [1:0] {PhaseAllOnes, PhaseEmpty, PhaseOversize, PhaseRandom} phase_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [63:0] value;
    logic [7:0]  text;
    bit          last;
    expect_e     mode;
    out_beat_t   beat;
  } plan_row_t;

  // DUT connections
  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [7:0]          s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tready = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [CfgAddrW-1:0] paddr    = '0;
  logic [CfgDataW-1:0] pwdata   = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic [15:0]         m_tdata;
  logic                m_tuser;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Shadow configuration and search state
  logic [63:0] pat_reg [4];
  logic [5:0]  pat_len;
  bit          fold_on;
  logic [7:0]  window [32];
  logic [15:0] seen;
  bit          reported;

  out_beat_t   verdicts_due[$];
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  substring_search_matcher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] text_byte
    .s_axis_tlast_i  (s_tlast),   // final_byte
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [15:0] match_start
    .m_axis_tuser_o  (m_tuser),   // [0] found
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Hard stop if the run hangs
  initial begin
    #RunLimit;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------- search model

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (fold_on && c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_at(input int i);
    return pat_reg[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  function automatic void clear_text();
    foreach (window[k]) window[k] = 8'h00;
    seen     = '0;
    reported = 1'b0;
  endfunction

  // Advance the search by one text byte; hit says a verdict falls due
  function automatic void match_step(input logic [7:0] b, input bit last,
                                     output bit hit, output out_beat_t v);
    int n;
    int k;
    bit eq;
    n   = (pat_len > 6'd32) ? 32 : int'(pat_len);
    hit = 1'b0;
    v   = '0;
    for (k = 31; k > 0; k--) window[k] = window[k - 1];
    window[0] = b;
    if (!reported && n > 0 && int'(seen) >= n - 1) begin
      eq = 1'b1;
      for (k = 0; k < n; k++) begin
        if (upcase(window[k]) != upcase(pat_at(n - 1 - k))) eq = 1'b0;
      end
      if (eq) begin
        v.found  = 1'b1;
        v.start  = (seen == 16'hFFFF) ? 16'hFFFF : seen - 16'(n - 1);
        reported = 1'b1;
        hit      = 1'b1;
      end
    end
    if (seen != 16'hFFFF) seen++;
    if (last) begin
      if (!hit && !reported) begin
        v   = '0;
        hit = 1'b1;
      end
      clear_text();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Drive one text beat and hold it until it is taken
  task automatic push_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic feed(input logic [7:0] b, input bit last, input expect_e mode,
                      input out_beat_t typed);
    bit        hit;
    out_beat_t v;
    push_byte(b, last);
    match_step(b, last, hit, v);
    case (mode)
      ExpPredict: if (hit) verdicts_due.push_back(v);
      ExpBeat:    verdicts_due.push_back(typed);
      default:    ;
    endcase
  endtask

  // Drop valid and wait until every verdict is in and the pipe is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [63:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPatLow, RegPatSecond, RegPatThird, RegPatHigh: pat_reg[idx] = value;
      RegPatLength: pat_len = value[5:0];
      RegCaseIns:   fold_on = value[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall the result side in short bursts
  initial begin : rx_stall
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        if (hold == 0) m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 5);
        m_tready <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest verdict due
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat found=%0b start=%0d", m_tuser, m_tdata));
      end else begin
        want = verdicts_due.pop_front();
        if (m_tuser !== want.found) begin
          flag_mismatch($sformatf("found %0b, want %0b", m_tuser, want.found));
        end
        if (m_tdata !== want.start) begin
          flag_mismatch($sformatf("match_start %0d, want %0d", m_tdata, want.start));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] value);
    plan_row_t r;
    r = '{kind: RowCfg, reg_idx: idx, value: value, text: 8'h00, last: 1'b0,
          mode: ExpNone, beat: '0};
    plan.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit last, input expect_e mode,
                                   input bit found = 1'b0, input logic [15:0] start = '0);
    plan_row_t r;
    r = '{kind: RowText, reg_idx: RegPatLow, value: '0, text: b, last: last,
          mode: mode, beat: '{found: found, start: start}};
    plan.push_back(r);
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A);
  endfunction

  // Flip letter case, often when folding is on, rarely when it is off
  function automatic logic [7:0] vary_case(input logic [7:0] b);
    if (is_letter(b) && $urandom_range(0, fold_on ? 1 : 19) == 0) return b ^ 8'h20;
    return b;
  endfunction

  function automatic logic [7:0] filler(input int n);
    if (n != 0 && $urandom_range(0, 1) == 0) return vary_case(pat_at($urandom_range(0, n - 1)));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic configure(input phase_e kind);
    logic [63:0] w [4];
    logic [5:0]  len;
    bit          narrow;
    int          b;
    narrow = $urandom_range(0, 1);
    for (b = 0; b < 32; b++) begin
      if (narrow) w[b >> 3][(b & 7) * 8 +: 8] = 8'h41 + 8'($urandom_range(0, 1))
                                                | 8'($urandom_range(0, 1) << 5);
      else        w[b >> 3][(b & 7) * 8 +: 8] = 8'($urandom_range(1, 255));
    end
    case ($urandom_range(0, 9))
      0:       len = 6'd0;
      7:       len = 6'($urandom_range(5, 32));
      8:       len = 6'd32;
      9:       len = 6'($urandom_range(33, 63));
      default: len = 6'($urandom_range(1, 4));
    endcase
    case (kind)
      PhaseAllOnes: begin
        foreach (w[i]) w[i] = '1;
        len = 6'd32;
      end
      PhaseEmpty: begin
        foreach (w[i]) w[i] = '0;
        len = 6'd0;
      end
      PhaseOversize: len = 6'($urandom_range(33, 63));
      default: ;
    endcase
    for (b = 0; b < 4; b++) set_reg(RegPatLow + 3'(b), w[b]);
    set_reg(RegPatLength, 64'(len));
    set_reg(RegCaseIns, 64'($urandom_range(0, 1)));
  endtask

  // Texts with the pattern planted, varied in case or broken, and plain noise
  task automatic run_phase(input phase_e kind, input int unsigned budget, input bit leave_open);
    logic [7:0]  txt[$];
    int unsigned fed;
    int          len_t;
    int          p;
    int          n;
    int          k;
    bit          open_end;
    configure(kind);
    n   = (pat_len > 6'd32) ? 32 : int'(pat_len);
    fed = 0;
    while (fed < budget) begin
      txt.delete();
      len_t = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
      if (n != 0 && $urandom_range(0, 9) < 7) begin
        if (len_t < n) len_t = n + $urandom_range(0, 8);
        p = $urandom_range(0, len_t - n);
      end else begin
        p = len_t;
      end
      for (k = 0; k < len_t; k++) begin
        if (k >= p && k < p + n) txt.push_back(vary_case(pat_at(k - p)));
        else txt.push_back(filler(n));
      end
      // corrupt one planted byte now and then
      if (p < len_t && $urandom_range(0, 9) == 0) begin
        txt[p + $urandom_range(0, n - 1)] = 8'($urandom_range(1, 255));
      end
      open_end = leave_open && (fed + len_t >= budget);
      for (k = 0; k < len_t; k++) feed(txt[k], (k == len_t - 1) && !open_end, ExpPredict, '0);
      fed += len_t;
    end
  endtask

  initial begin : stimulus
    int     ph;
    phase_e kind;
    foreach (pat_reg[i]) pat_reg[i] = '0;
    pat_len = '0;
    fold_on = 1'b0;
    clear_text();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern after reset: only the final byte answers
    add_byte(8'h41, 1'b1, ExpBeat, 1'b0, 16'd0);
    // exact match inside the text, then nothing more for that text
    add_cfg(RegPatLow, 64'h434241);
    add_cfg(RegPatLength, 64'd3);
    add_byte(8'h5A, 1'b0, ExpNone);
    add_byte(8'h41, 1'b0, ExpNone);
    add_byte(8'h42, 1'b0, ExpNone);
    add_byte(8'h43, 1'b0, ExpBeat, 1'b1, 16'd1);
    add_byte(8'h44, 1'b1, ExpNone);
    // folded match ending on the final byte
    add_cfg(RegCaseIns, 64'd1);
    add_byte(8'h61, 1'b0, ExpNone);
    add_byte(8'h62, 1'b0, ExpNone);
    add_byte(8'h63, 1'b1, ExpBeat, 1'b1, 16'd0);
    add_byte(8'h71, 1'b0, ExpPredict);
    add_byte(8'h61, 1'b0, ExpPredict);
    add_byte(8'h42, 1'b0, ExpPredict);
    add_byte(8'h63, 1'b1, ExpPredict);
    // length above the maximum clips to 32, so two bytes cannot match
    add_cfg(RegPatLength, 64'd63);
    add_byte(8'h80, 1'b0, ExpNone);
    add_byte(8'h7F, 1'b1, ExpBeat, 1'b0, 16'd0);
    // a zero byte takes part in the comparison
    add_cfg(RegPatLow, 64'h4100);
    add_cfg(RegPatLength, 64'd2);
    add_byte(8'h00, 1'b0, ExpNone);
    add_byte(8'h61, 1'b1, ExpBeat, 1'b1, 16'd0);
    // top byte value, case exact
    add_cfg(RegPatLow, 64'hFF);
    add_cfg(RegPatLength, 64'd1);
    add_cfg(RegCaseIns, 64'd0);
    add_byte(8'h01, 1'b0, ExpNone);
    add_byte(8'hFF, 1'b1, ExpBeat, 1'b1, 16'd1);
    // without folding the letter case matters
    add_cfg(RegPatLow, 64'h61);
    add_byte(8'h41, 1'b1, ExpBeat, 1'b0, 16'd0);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) set_reg(plan[i].reg_idx, plan[i].value);
      else feed(plan[i].text, plan[i].last, plan[i].mode, plan[i].beat);
    end

    // random phases, extremes first; the last two run without idling
    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       kind = PhaseAllOnes;
        1:       kind = PhaseEmpty;
        2:       kind = PhaseOversize;
        default: kind = PhaseRandom;
      endcase
      if (ph >= PhaseCount - 2) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      run_phase(kind, PhaseItems, (ph != PhaseCount - 1) && ($urandom_range(0, 2) == 0));
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
